[rtl/mpjs_pkg.sv]
// ----------------------------------------------------------------------------
// mpjs_pkg - shared types and constants of the multi-policy job scheduler
// Job record layout, command and policy codes, status codes and defaults.
// ----------------------------------------------------------------------------
package mpjs_pkg;

	localparam int SLOTS_DEF = 16;
	localparam logic [23:0] MAX24 = 24'hFFFFFF;

	typedef enum logic [1:0] {
		CMD_NEW     = 2'd0,
		CMD_QUANTUM = 2'd1,
		CMD_FINISH  = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	localparam logic [2:0] POL_FCFS  = 3'd0;
	localparam logic [2:0] POL_PRI   = 3'd1;
	localparam logic [2:0] POL_PPRI  = 3'd2;
	localparam logic [2:0] POL_PSRTF = 3'd3;
	localparam logic [2:0] POL_RR    = 3'd4;
	localparam logic [2:0] POL_SJF   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_NOTFD = 2'd2;

	typedef struct packed {
		logic [15:0] job;
		logic [31:0] arrival;
		logic [23:0] run;
		logic [23:0] remaining;
		logic        started;
		logic [31:0] svc_begin;
		logic [7:0]  prio;
		logic [23:0] quanta;
	} rec_t;

endpackage

[rtl/mpjs_ram.sv]
// ----------------------------------------------------------------------------
// mpjs_ram - generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mpjs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/multi_policy_job_scheduler.sv]
// ----------------------------------------------------------------------------
// multi_policy_job_scheduler - job table with six selection policies
// Stores job records in a RAM and sweeps it once per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   new job, quantum expired, or job finished. Each command yields exactly
//   one result transaction on out_valid/out_ready with the chosen job, a
//   status and the running totals.
//   cfg_we/cfg_wdata write the policy register; write it only while idle.
//   Every command sweeps all SLOTS records through the record RAM, one read
//   per cycle, then passes through drain, write-back, accumulate and done
//   before its result is loaded into the output register.
//   One command is in work at a time; the next one is taken while the last
//   result still waits in the output register.
//   Reset clears the slot valid bits, the totals and the policy (FCFS).
//   Record contents are not cleared; a slot is fully written when filled.
//   When the receiver stalls, the result holds in the output register and
//   the block stops before loading the following result.
// ----------------------------------------------------------------------------
module multi_policy_job_scheduler #(
	parameter int SLOTS = mpjs_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   cmd,
	input  logic         has_job,
	input  logic [15:0]  job_id,
	input  logic [31:0]  now,
	input  logic [23:0]  run_length,
	input  logic [7:0]   job_priority,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         next_valid,
	output logic [15:0]  next_job_id,
	output logic [1:0]   status,
	output logic [31:0]  jobs_done,
	output logic [47:0]  sum_wait,
	output logic [47:0]  sum_turnaround,
	output logic [47:0]  sum_response
);

	localparam int IW = $clog2(SLOTS);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_WB, S_ACC, S_DONE} state_t;

	state_t           state_q;
	logic [2:0]       policy_q;
	logic [IW:0]      cnt_q;
	logic [SLOTS-1:0] used_q;

	// latched command
	mpjs_pkg::cmd_t cmd_q;
	logic           has_job_q;
	logic [15:0]    id_q;
	logic [31:0]    now_q;
	logic [23:0]    run_q;
	logic [7:0]     prio_q;

	// read pipeline
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	mpjs_pkg::rec_t rd_rec;

	// sweep results
	logic           best_vld_q;
	logic [31:0]    best_key_q;
	logic [31:0]    best_arr_q;
	logic [15:0]    best_job_q;
	logic           cur_fnd_q;
	logic [IW-1:0]  cur_idx_q;
	mpjs_pkg::rec_t cur_rec_q;
	logic           free_fnd_q;
	logic [IW-1:0]  free_idx_q;

	// totals and deltas
	logic [31:0] count_q;
	logic [47:0] wait_q, turn_q, resp_q;
	logic [47:0] d_wait_q, d_turn_q, d_resp_q;
	logic        fin_q;

	// result waiting for the output register
	logic        res_vld_q;
	logic [15:0] res_job_q;
	logic [1:0]  res_st_q;

	// output register
	logic        out_vld_q;
	logic        out_nv_q;
	logic [15:0] out_job_q;
	logic [1:0]  out_st_q;
	logic [31:0] out_cnt_q;
	logic [47:0] out_wait_q, out_turn_q, out_resp_q;

	// RAM ports
	logic           ram_we;
	logic [IW-1:0]  ram_waddr;
	mpjs_pkg::rec_t ram_wdata;
	logic [$bits(mpjs_pkg::rec_t)-1:0] ram_rdata;

	mpjs_ram #(
		.WIDTH($bits(mpjs_pkg::rec_t)),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_rec = mpjs_pkg::rec_t'(ram_rdata);

	// per-slot evaluation of the record coming out of the RAM
	logic           lookup;
	logic           slot_used;
	logic           match;
	mpjs_pkg::rec_t charged;
	mpjs_pkg::rec_t eff;
	logic [31:0]    key;
	logic           better;
	logic           nonpre;

	always_comb begin
		lookup = (cmd_q == mpjs_pkg::CMD_FINISH) ||
		         (cmd_q == mpjs_pkg::CMD_QUANTUM && has_job_q);
		slot_used = used_q[rd_idx_s1];
		match = rd_vld_s1 && slot_used && lookup && !cur_fnd_q && (rd_rec.job == id_q);
		charged = rd_rec;
		if (!rd_rec.started) begin
			charged.started   = 1'b1;
			charged.svc_begin = now_q - 32'd1;
		end
		if (rd_rec.remaining != 24'd0) begin
			charged.remaining = rd_rec.remaining - 24'd1;
		end
		if (rd_rec.quanta != mpjs_pkg::MAX24) begin
			charged.quanta = rd_rec.quanta + 24'd1;
		end
		eff = (match && cmd_q == mpjs_pkg::CMD_QUANTUM) ? charged : rd_rec;
		case (policy_q)
			mpjs_pkg::POL_PRI,
			mpjs_pkg::POL_PPRI:  key = {24'd0, eff.prio};
			mpjs_pkg::POL_PSRTF: key = {8'd0, eff.remaining};
			mpjs_pkg::POL_RR:    key = {8'd0, eff.quanta};
			mpjs_pkg::POL_SJF:   key = {8'd0, eff.run};
			default:             key = eff.arrival;
		endcase
		better = !best_vld_q || (key < best_key_q) ||
		         (key == best_key_q && eff.arrival < best_arr_q);
		nonpre = !(policy_q == mpjs_pkg::POL_PPRI || policy_q == mpjs_pkg::POL_PSRTF ||
		           policy_q == mpjs_pkg::POL_RR);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_idx_q;
		ram_wdata = cur_rec_q;
		if (state_q == S_WB) begin
			if (cmd_q == mpjs_pkg::CMD_NEW && free_fnd_q) begin
				ram_we    = 1'b1;
				ram_waddr = free_idx_q;
				ram_wdata = '{job: id_q, arrival: now_q, run: run_q, remaining: run_q,
				              started: 1'b0, svc_begin: 32'd0, prio: prio_q,
				              quanta: 24'd0};
			end else if (cmd_q == mpjs_pkg::CMD_QUANTUM && lookup && cur_fnd_q) begin
				ram_we = 1'b1;
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			policy_q   <= mpjs_pkg::POL_FCFS;
			cnt_q      <= '0;
			used_q     <= '0;
			rd_vld_s1  <= 1'b0;
			count_q    <= '0;
			wait_q     <= '0;
			turn_q     <= '0;
			resp_q     <= '0;
			out_vld_q  <= 1'b0;
			best_vld_q <= 1'b0;
			cur_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
			fin_q      <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			// drop the result once taken, unless a new one is loaded this cycle
			if (out_vld_q && out_ready && state_q != S_DONE) begin
				out_vld_q <= 1'b0;
			end

			// sweep evaluation
			if (rd_vld_s1) begin
				if (slot_used && better) begin
					best_vld_q <= 1'b1;
					best_key_q <= key;
					best_arr_q <= eff.arrival;
					best_job_q <= eff.job;
				end
				if (match) begin
					cur_fnd_q <= 1'b1;
					cur_idx_q <= rd_idx_s1;
					cur_rec_q <= eff;
				end
				if (!slot_used && !free_fnd_q) begin
					free_fnd_q <= 1'b1;
					free_idx_q <= rd_idx_s1;
				end
			end

			case (state_q)
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (in_valid) begin
						cmd_q      <= mpjs_pkg::cmd_t'(cmd);
						has_job_q  <= has_job;
						id_q       <= job_id;
						now_q      <= now;
						run_q      <= run_length;
						prio_q     <= job_priority;
						cnt_q      <= '0;
						best_vld_q <= 1'b0;
						cur_fnd_q  <= 1'b0;
						free_fnd_q <= 1'b0;
						fin_q      <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue one read per cycle; data is evaluated once the registered read returns
					rd_vld_s1 <= 1'b1;
					rd_idx_s1 <= cnt_q[IW-1:0];
					cnt_q     <= cnt_q + 1'b1;
					if (cnt_q == (IW+1)'(SLOTS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					rd_vld_s1 <= 1'b0;
					state_q   <= S_WB;
				end
				S_WB: begin
					res_st_q  <= mpjs_pkg::ST_OK;
					res_vld_q <= 1'b0;
					res_job_q <= 16'd0;
					case (cmd_q)
						mpjs_pkg::CMD_NEW: begin
							if (free_fnd_q) begin
								used_q[free_idx_q] <= 1'b1;
							end else begin
								res_st_q <= mpjs_pkg::ST_FULL;
							end
						end
						mpjs_pkg::CMD_QUANTUM: begin
							if (lookup && !cur_fnd_q) begin
								res_st_q <= mpjs_pkg::ST_NOTFD;
							end
							if (lookup && cur_fnd_q && nonpre) begin
								res_vld_q <= 1'b1;
								res_job_q <= cur_rec_q.job;
							end else if (best_vld_q) begin
								res_vld_q <= 1'b1;
								res_job_q <= best_job_q;
							end
						end
						mpjs_pkg::CMD_FINISH: begin
							if (cur_fnd_q) begin
								used_q[cur_idx_q] <= 1'b0;
								fin_q    <= 1'b1;
								d_resp_q <= (cur_rec_q.started ? {16'd0, cur_rec_q.svc_begin}
								                               : {48{1'b1}})
								            - {16'd0, cur_rec_q.arrival};
								d_turn_q <= {16'd0, now_q} - {16'd0, cur_rec_q.arrival};
								d_wait_q <= {16'd0, now_q} - {16'd0, cur_rec_q.arrival}
								            - {24'd0, cur_rec_q.run};
							end else begin
								res_st_q <= mpjs_pkg::ST_NOTFD;
							end
						end
						default: begin
						end
					endcase
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (fin_q) begin
						count_q <= count_q + 32'd1;
						resp_q  <= resp_q + d_resp_q;
						turn_q  <= turn_q + d_turn_q;
						wait_q  <= wait_q + d_wait_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_vld_q || out_ready) begin
						out_vld_q  <= 1'b1;
						out_nv_q   <= res_vld_q;
						out_job_q  <= res_job_q;
						out_st_q   <= res_st_q;
						out_cnt_q  <= count_q;
						out_wait_q <= wait_q;
						out_turn_q <= turn_q;
						out_resp_q <= resp_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_vld_q;
	assign next_valid     = out_nv_q;
	assign next_job_id    = out_job_q;
	assign status         = out_st_q;
	assign jobs_done      = out_cnt_q;
	assign sum_wait       = out_wait_q;
	assign sum_turnaround = out_turn_q;
	assign sum_response   = out_resp_q;

	a_full_no_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mpjs_pkg::ST_FULL |-> !next_valid)
		else $error("table-full result carries a chosen job");

	a_ram_we_wb: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_WB)
		else $error("record RAM written outside write-back");

	a_used_wb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_WB |=> $stable(used_q))
		else $error("slot valid bits changed outside write-back");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> count_q == $past(count_q) + 32'd1)
		else $error("finished count moved by other than one");

endmodule
